### hdl/edwf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the event duplicate window filter.
package edwf_pkg;

  // History depth default (1 to 256 entries)
  localparam int HISTORY_DEPTH_DEF = 16;

  // Configuration register map
  localparam int          CFG_IDX_W   = 2;
  localparam logic [1:0]  CFG_TOL_IDX = 2'd0;
  localparam logic [1:0]  CFG_END_IDX = 2'd1;

  // Register reset values: 50 ms tolerance
  localparam logic [15:0] TOL_RESET = 16'd50;
  localparam logic [7:0]  END_RESET = 8'd0;

  // Result status codes
  localparam logic [1:0] ST_STORED  = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_STORE,
    S_RESULT
  } state_t;

  // One history entry: time plus type and participant list
  typedef struct packed {
    logic [31:0] ts;
    logic [7:0]  ev_type;
    logic [1:0]  cnt;
    logic [15:0] id0;
    logic [15:0] id1;
  } hist_entry_t;

endpackage

### hdl/edwf_history.sv
`timescale 1ns / 1ps
// History ring: entry memory, write pointer and fill count.
module edwf_history #(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  edwf_pkg::hist_entry_t wr_entry,
  input  logic [AW-1:0]         rd_addr,
  output edwf_pkg::hist_entry_t rd_entry,
  output logic [CW-1:0]         fill
);
  import edwf_pkg::*;

  hist_entry_t   hist_mem [DEPTH];
  hist_entry_t   rd_entry_r;
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] wr_ptr_nxt;
  logic [CW-1:0] fill_r;
  logic [CW-1:0] fill_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[wr_ptr_r] <= wr_entry;
    end
    rd_entry_r <= hist_mem[rd_addr];
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    fill_nxt   = fill_r;
    if (wr_en) begin
      if (wr_ptr_r == AW'(DEPTH - 1)) begin
        wr_ptr_nxt = '0;
      end else begin
        wr_ptr_nxt = wr_ptr_r + AW'(1);
      end
      if (fill_r != CW'(DEPTH)) begin
        fill_nxt = fill_r + CW'(1);
      end
    end
  end

  // entries 0 .. fill-1 are live: the ring fills in order from entry 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  assign rd_entry = rd_entry_r;
  assign fill     = fill_r;

endmodule

### hdl/event_dedup_window_filter.sv
`timescale 1ns / 1ps
// Event duplicate window filter: top level with scan sequencer and compare unit.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_ready  | event type, timestamp, cause, effect
//  out     | out_valid / out_ready| status, stream_ended
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (tolerance, end type)
//
// One item at a time. An item is accepted, compared against each live
// history entry in turn through the shared time/tag compare unit (fed by the
// registered memory read port), stored and given a result; the scan stops
// early on a duplicate, which is not stored.
// Items after the end event go straight from accept to the result.
// Reset (synchronous, rst_n low) empties the ring at once via the fill count.
// A result waiting on out_ready holds the sequencer in its result state;
// an earlier result still pending does not block acceptance of the next item.
module event_dedup_window_filter #(
  parameter int HISTORY_DEPTH = edwf_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_event_type,
  input  logic [31:0]                   in_timestamp_ms,
  input  logic                          in_cause_present,
  input  logic [3:0]                    in_cause_slot,
  input  logic [15:0]                   in_cause_name_id,
  input  logic                          in_effect_present,
  input  logic [3:0]                    in_effect_slot,
  input  logic [15:0]                   in_effect_name_id,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic                          out_stream_ended,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [edwf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);
  import edwf_pkg::*;

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);

  state_t        state_r, state_nxt;
  logic [AW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic          ended_r, ended_nxt;
  logic [15:0]   tol_r;
  logic [7:0]    end_type_r;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic          out_ended_r, out_ended_nxt;

  // latched item (payload, no reset)
  hist_entry_t   item_r, item_nxt;

  // history ring
  logic          wr_en;
  logic [AW-1:0] rd_addr;
  hist_entry_t   rd_entry;
  logic [CW-1:0] fill;

  // compare unit
  logic [32:0]   diff_a;
  logic [32:0]   diff_b;
  logic [31:0]   abs_diff;
  logic          near;
  logic          ids_match;
  logic          hit;
  logic          last_entry;

  // item intake
  logic          in_acc;
  logic          eff_listed;
  hist_entry_t   new_entry;

  edwf_history #(
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_entry (item_r),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .fill     (fill)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // participant list: cause first, effect only if its slot differs
  assign eff_listed = in_effect_present && (in_effect_slot != in_cause_slot);

  always_comb begin
    new_entry.ts      = in_timestamp_ms;
    new_entry.ev_type = in_event_type;
    new_entry.cnt     = 2'({1'b0, in_cause_present} + {1'b0, eff_listed});
    new_entry.id0     = in_cause_present ? in_cause_name_id :
                        (eff_listed ? in_effect_name_id : 16'd0);
    new_entry.id1     = (in_cause_present && eff_listed) ? in_effect_name_id : 16'd0;
  end

  // shared compare unit, one stored entry per cycle
  assign diff_a   = {1'b0, rd_entry.ts} - {1'b0, item_r.ts};
  assign diff_b   = {1'b0, item_r.ts} - {1'b0, rd_entry.ts};
  assign abs_diff = diff_a[32] ? diff_b[31:0] : diff_a[31:0];
  assign near     = abs_diff < {16'd0, tol_r};

  // each new id must appear in the stored list; counts already equal
  always_comb begin
    case (item_r.cnt)
      2'd0:    ids_match = 1'b1;
      2'd1:    ids_match = (item_r.id0 == rd_entry.id0);
      2'd2:    ids_match = ((item_r.id0 == rd_entry.id0) || (item_r.id0 == rd_entry.id1)) &&
                           ((item_r.id1 == rd_entry.id0) || (item_r.id1 == rd_entry.id1));
      default: ids_match = 1'b0;
    endcase
  end

  assign hit = near && (rd_entry.ev_type == item_r.ev_type) &&
               (rd_entry.cnt == item_r.cnt) && ids_match;

  assign last_entry = ((CW'(cmp_idx_r) + CW'(1)) == fill);

  // next entry is requested while the current one is compared
  assign rd_addr = (state_r == S_SCAN) ? (cmp_idx_r + AW'(1)) : '0;
  assign wr_en   = (state_r == S_STORE);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cmp_idx_nxt    = cmp_idx_r;
    res_status_nxt = res_status_r;
    ended_nxt      = ended_r;
    item_nxt       = item_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_ended_nxt  = out_ended_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          item_nxt    = new_entry;
          cmp_idx_nxt = '0;
          if (ended_r) begin
            res_status_nxt = ST_IGNORED;
            state_nxt      = S_RESULT;
          end else if (fill == '0) begin
            state_nxt = S_STORE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_status_nxt = ST_DUP;
          state_nxt      = S_RESULT;
        end else if (last_entry) begin
          state_nxt = S_STORE;
        end else begin
          cmp_idx_nxt = cmp_idx_r + AW'(1);
        end
      end
      S_STORE: begin
        res_status_nxt = ST_STORED;
        if (item_r.ev_type == end_type_r) begin
          ended_nxt = 1'b1;
        end
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_ended_nxt  = ended_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ended_r     <= ended_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    res_status_r <= res_status_nxt;
    out_status_r <= out_status_nxt;
    out_ended_r  <= out_ended_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r      <= TOL_RESET;
      end_type_r <= END_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TOL_IDX: tol_r      <= cfg_data;
        CFG_END_IDX: end_type_r <= cfg_data[7:0];
        default:     ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_stream_ended = out_ended_r;

  // end of stream is sticky until reset
  a_ended_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |=> ended_r)
    else $error("end flag cleared without reset");

  // ignored items only ever report an ended stream, duplicates never do
  a_ignored_ended: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_IGNORED)) |-> out_stream_ended)
    else $error("ignored item reported with stream not ended");

  a_dup_not_ended: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_DUP)) |-> !out_stream_ended)
    else $error("duplicate reported with stream ended");

  // one item at a time: the intake is closed in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("intake reopened straight after an accept");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= CW'(HISTORY_DEPTH))
    else $error("history fill count beyond depth");

endmodule

### dv/event_dedup_window_filter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the event duplicate window filter.
module event_dedup_window_filter_tb;
  import edwf_pkg::*;

  localparam int         DEPTH          = HISTORY_DEPTH_DEF;
  // index 3 is not in the register map; a write there must change nothing
  localparam logic [1:0] CFG_SPARE_IDX  = 2'd3;
  localparam int         RECENT_KEEP    = 24;
  localparam int         PHASE_ITEMS    = 210;
  localparam int         REPORT_LIMIT   = 10;
  localparam int         DIR_ROWS_MAX   = 32;
  localparam int         OUTCOME_SLOTS  = 16;

  // one input item as the filter sees it
  typedef struct packed {
    logic [7:0]  event_type;
    logic [31:0] timestamp_ms;
    logic        cause_present;
    logic [3:0]  cause_slot;
    logic [15:0] cause_name_id;
    logic        effect_present;
    logic [3:0]  effect_slot;
    logic [15:0] effect_name_id;
  } event_t;

  // one result item
  typedef struct packed {
    logic [1:0] status;
    logic       ended;
  } outcome_t;

  typedef enum logic {ROW_EVENT, ROW_REG} row_kind_e;

  // directed stimulus row: either a register write or an item, the latter
  // optionally carrying a hand-written expectation
  typedef struct packed {
    row_kind_e  kind;
    logic [1:0] reg_idx;
    logic [15:0] reg_data;
    event_t     ev;
    logic       typed;
    outcome_t   want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_event_type;
  logic [31:0] in_timestamp_ms;
  logic        in_cause_present;
  logic [3:0]  in_cause_slot;
  logic [15:0] in_cause_name_id;
  logic        in_effect_present;
  logic [3:0]  in_effect_slot;
  logic [15:0] in_effect_name_id;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic        out_stream_ended;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  // filter state as this bench believes it to be
  hist_entry_t      ring [DEPTH];
  logic [DEPTH-1:0] ring_live;
  int               ring_wr;
  logic             stream_done;
  logic [15:0]      window_ms;
  logic [7:0]       end_code;

  // expected results in order: written at accept, read at each result
  outcome_t outcome_fifo [OUTCOME_SLOTS];
  int       outcome_wr;
  int       outcome_rd;

  // last few items sent, kept as a small ring for near-repeats
  event_t   recent_events [RECENT_KEEP];
  int       recent_count;
  int       recent_wr;

  row_t     dir_rows [DIR_ROWS_MAX];
  int       dir_count;

  logic [31:0] time_base;
  logic     steady_in;
  logic     steady_out;
  int       fault_count;

  event_dedup_window_filter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_event_type     (in_event_type),
    .in_timestamp_ms   (in_timestamp_ms),
    .in_cause_present  (in_cause_present),
    .in_cause_slot     (in_cause_slot),
    .in_cause_name_id  (in_cause_name_id),
    .in_effect_present (in_effect_present),
    .in_effect_slot    (in_effect_slot),
    .in_effect_name_id (in_effect_name_id),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_stream_ended  (out_stream_ended),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Works out the result of one accepted item and advances the ring.
  // Participant list: cause first if present, effect after it if present and
  // in a different slot. Lists match on equal length with every new id found
  // somewhere in the stored list.
  function automatic outcome_t judge_event(input event_t ev);
    outcome_t          res;
    logic [1:0][15:0]  ids;
    int                cnt;
    int                k;
    int                j;
    logic [31:0]       t_apart;
    logic              hit;
    logic              dup;
    hist_entry_t       cand;
    res = '0;
    ids = '0;
    cnt = 0;
    dup = 1'b0;
    if (stream_done) begin
      res.status = ST_IGNORED;
      res.ended  = 1'b1;
      return res;
    end
    if (ev.cause_present) begin
      ids[cnt] = ev.cause_name_id;
      cnt++;
    end
    if (ev.effect_present && ev.effect_slot != ev.cause_slot) begin
      ids[cnt] = ev.effect_name_id;
      cnt++;
    end
    for (k = 0; k < DEPTH; k++) begin
      cand = ring[k];
      // exact distance, no wrap of the 32-bit clock
      t_apart = (cand.ts > ev.timestamp_ms) ? cand.ts - ev.timestamp_ms
                                            : ev.timestamp_ms - cand.ts;
      if (ring_live[k] && !dup && t_apart < {16'd0, window_ms} &&
          cand.ev_type == ev.event_type && int'(cand.cnt) == cnt) begin
        hit = 1'b1;
        for (j = 0; j < cnt; j++) begin
          if (!((cand.cnt >= 2'd1 && ids[j] == cand.id0) ||
                (cand.cnt >= 2'd2 && ids[j] == cand.id1)))
            hit = 1'b0;
        end
        dup = hit;
      end
    end
    if (dup) begin
      res.status = ST_DUP;
      res.ended  = 1'b0;
      return res;
    end
    ring[ring_wr].ts      = ev.timestamp_ms;
    ring[ring_wr].ev_type = ev.event_type;
    ring[ring_wr].cnt     = 2'(cnt);
    ring[ring_wr].id0     = ids[0];
    ring[ring_wr].id1     = ids[1];
    ring_live[ring_wr]    = 1'b1;
    ring_wr = (ring_wr == DEPTH - 1) ? 0 : ring_wr + 1;
    // only a stored end-type item ends the stream, never a dropped one
    if (ev.event_type == end_code)
      stream_done = 1'b1;
    res.status = ST_STORED;
    res.ended  = stream_done;
    return res;
  endfunction

  function automatic event_t mk_event(input logic [7:0] typ, input logic [31:0] ts,
                                      input logic cp, input logic [3:0] cs,
                                      input logic [15:0] cid, input logic ep,
                                      input logic [3:0] es, input logic [15:0] eid);
    event_t ev;
    ev.event_type     = typ;
    ev.timestamp_ms   = ts;
    ev.cause_present  = cp;
    ev.cause_slot     = cs;
    ev.cause_name_id  = cid;
    ev.effect_present = ep;
    ev.effect_slot    = es;
    ev.effect_name_id = eid;
    return ev;
  endfunction

  function automatic row_t event_row(input event_t ev);
    row_t row;
    row      = '0;
    row.kind = ROW_EVENT;
    row.ev   = ev;
    return row;
  endfunction

  function automatic row_t typed_row(input event_t ev, input logic [1:0] st,
                                     input logic en);
    row_t row;
    row             = event_row(ev);
    row.typed       = 1'b1;
    row.want.status = st;
    row.want.ended  = en;
    return row;
  endfunction

  function automatic row_t reg_row(input logic [1:0] idx, input logic [15:0] data);
    row_t row;
    row          = '0;
    row.kind     = ROW_REG;
    row.reg_idx  = idx;
    row.reg_data = data;
    return row;
  endfunction

  function automatic void add_row(input row_t row);
    dir_rows[dir_count] = row;
    dir_count++;
  endfunction

  // Random item. Most often a near-repeat of a recent item (so duplicates and
  // near misses are frequent), then fresh items from a small id/type pool,
  // then raw noise over every bit. The current end type is steered clear of
  // so the stream stays open until the closing sequence.
  function automatic event_t draw_event();
    event_t      ev;
    int          pick;
    logic [31:0] span;
    logic [31:0] delta;
    span = (window_ms == 16'd0) ? 32'd4 : {16'd0, window_ms};
    pick = $urandom_range(0, 99);
    if (pick < 45 && recent_count != 0) begin
      ev    = recent_events[$urandom_range(0, recent_count - 1)];
      delta = $urandom_range(0, span + span / 4);
      ev.timestamp_ms = ($urandom_range(0, 1) != 0) ? ev.timestamp_ms + delta
                                                    : ev.timestamp_ms - delta;
      case ($urandom_range(0, 7))
        0: begin
          {ev.cause_name_id, ev.effect_name_id} = {ev.effect_name_id, ev.cause_name_id};
          ev.cause_present  = 1'b1;
          ev.effect_present = 1'b1;
        end
        1: ev.effect_slot = ev.cause_slot;
        2: ev.event_type[0] = ~ev.event_type[0];
        3: ev.cause_present = ~ev.cause_present;
        4: ev.effect_name_id = 16'($urandom_range(0, 4));
        default: ;
      endcase
    end else if (pick < 88) begin
      time_base = time_base + $urandom_range(0, span);
      ev = mk_event(8'($urandom_range(0, 5)), time_base + $urandom_range(0, span),
                    $urandom_range(0, 3) != 0, 4'($urandom_range(0, 15)),
                    16'($urandom_range(0, 4)),
                    $urandom_range(0, 3) != 0, 4'($urandom_range(0, 15)),
                    16'($urandom_range(0, 4)));
    end else begin
      ev = mk_event(8'($urandom), $urandom, 1'($urandom), 4'($urandom), 16'($urandom),
                    1'($urandom), 4'($urandom), 16'($urandom));
    end
    if (ev.event_type == end_code)
      ev.event_type = ev.event_type ^ 8'h80;
    recent_events[recent_wr] = ev;
    recent_wr = (recent_wr == RECENT_KEEP - 1) ? 0 : recent_wr + 1;
    if (recent_count < RECENT_KEEP)
      recent_count++;
    return ev;
  endfunction

  // Offers one item after a random gap, waits for the handshake, then files
  // the expected result (hand-written or predicted; the ring advances anyway).
  task automatic push_event(input event_t ev, input logic typed, input outcome_t want);
    int       gap;
    outcome_t predicted;
    if ($urandom_range(0, 29) == 0)
      steady_in = ~steady_in;
    gap = steady_in ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_event_type     <= ev.event_type;
    in_timestamp_ms   <= ev.timestamp_ms;
    in_cause_present  <= ev.cause_present;
    in_cause_slot     <= ev.cause_slot;
    in_cause_name_id  <= ev.cause_name_id;
    in_effect_present <= ev.effect_present;
    in_effect_slot    <= ev.effect_slot;
    in_effect_name_id <= ev.effect_name_id;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predicted = judge_event(ev);
    outcome_fifo[outcome_wr % OUTCOME_SLOTS] = typed ? want : predicted;
    outcome_wr++;
  endtask

  // Register write, only once the filter has drained every item.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    in_valid <= 1'b0;
    while (outcome_wr != outcome_rd) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      CFG_TOL_IDX: window_ms = data;
      CFG_END_IDX: end_code  = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stall before each result, with stall-free stretches.
  initial begin
    int stall;
    out_ready  = 1'b0;
    steady_out = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 29) == 0)
        steady_out = ~steady_out;
      stall = steady_out ? 0 : $urandom_range(0, 12);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
        @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid === 1'b1 && out_ready === 1'b1)) @(posedge clk);
    end
  end

  // Result checker: every result must meet the oldest expectation.
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (outcome_wr == outcome_rd) begin
        if (fault_count < REPORT_LIMIT)
          $display("%0t: unexpected result status=%0d ended=%0b", $realtime,
                   out_status, out_stream_ended);
        fault_count++;
      end else begin
        want = outcome_fifo[outcome_rd % OUTCOME_SLOTS];
        outcome_rd++;
        if (out_status !== want.status || out_stream_ended !== want.ended) begin
          if (fault_count < REPORT_LIMIT)
            $display("%0t: result mismatch status exp=%0d got=%0d, ended exp=%0b got=%0b",
                     $realtime, want.status, out_status, want.ended, out_stream_ended);
          fault_count++;
        end
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("event_dedup_window_filter verification failed");
    $finish;
  end

  initial begin
    event_t anchor;
    int     ph;

    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_event_type     = '0;
    in_timestamp_ms   = '0;
    in_cause_present  = 1'b0;
    in_cause_slot     = '0;
    in_cause_name_id  = '0;
    in_effect_present = 1'b0;
    in_effect_slot    = '0;
    in_effect_name_id = '0;
    cfg_valid         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    steady_in         = 1'b0;
    fault_count       = 0;
    time_base         = $urandom;
    outcome_wr        = 0;
    outcome_rd        = 0;
    recent_count      = 0;
    recent_wr         = 0;
    dir_count         = 0;

    // predictor starts where reset leaves the filter: empty ring, 50 ms window
    ring_live   = '0;
    ring_wr     = 0;
    stream_done = 1'b0;
    window_ms   = TOL_RESET;
    end_code    = END_RESET;
    for (int k = 0; k < DEPTH; k++)
      ring[k] = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. End type moved off zero first so that type zero can be
    // exercised; the window keeps its reset value of 50 ms until the zero-window rows.
    add_row(reg_row(CFG_END_IDX, 16'd77));
    // window edge: 49 ms apart is the same time, 50 ms apart is not
    add_row(typed_row(mk_event(8'd0, 32'd0, 1'b0, 4'd0, 16'd0, 1'b0, 4'd0, 16'd0),
                      ST_STORED, 1'b0));
    add_row(typed_row(mk_event(8'd0, 32'd49, 1'b0, 4'd0, 16'd0, 1'b0, 4'd0, 16'd0),
                      ST_DUP, 1'b0));
    add_row(typed_row(mk_event(8'd0, 32'd50, 1'b0, 4'd0, 16'd0, 1'b0, 4'd0, 16'd0),
                      ST_STORED, 1'b0));
    // field extremes; then the same two ids in swapped order still match
    add_row(typed_row(mk_event(8'hFF, 32'hFFFF_FFFF, 1'b1, 4'd15, 16'hFFFF,
                               1'b1, 4'd0, 16'h0000), ST_STORED, 1'b0));
    add_row(typed_row(mk_event(8'hFF, 32'hFFFF_FFF6, 1'b1, 4'd3, 16'h0000,
                               1'b1, 4'd7, 16'hFFFF), ST_DUP, 1'b0));
    // effect in the cause's slot drops out of the list
    add_row(typed_row(mk_event(8'd10, 32'd1000, 1'b1, 4'd5, 16'd1, 1'b1, 4'd5, 16'd2),
                      ST_STORED, 1'b0));
    add_row(typed_row(mk_event(8'd10, 32'd1010, 1'b1, 4'd5, 16'd1, 1'b0, 4'd9, 16'd2),
                      ST_DUP, 1'b0));
    // lone effect gives the same one-id list
    add_row(typed_row(mk_event(8'd10, 32'd1020, 1'b0, 4'd0, 16'd0, 1'b1, 4'd2, 16'd1),
                      ST_DUP, 1'b0));
    // length mismatch, type mismatch
    add_row(event_row(mk_event(8'd10, 32'd1005, 1'b1, 4'd1, 16'd1, 1'b1, 4'd2, 16'd2)));
    add_row(event_row(mk_event(8'd11, 32'd1000, 1'b1, 4'd5, 16'd1, 1'b0, 4'd0, 16'd0)));
    // repeated ids are not counted separately
    add_row(event_row(mk_event(8'd20, 32'd2000, 1'b1, 4'd1, 16'd7, 1'b1, 4'd2, 16'd7)));
    add_row(event_row(mk_event(8'd20, 32'd2001, 1'b1, 4'd1, 16'd7, 1'b1, 4'd2, 16'd9)));
    add_row(event_row(mk_event(8'd20, 32'd2002, 1'b1, 4'd4, 16'd9, 1'b1, 4'd6, 16'd7)));
    // time distance has no wrap-around
    add_row(event_row(mk_event(8'd30, 32'd0, 1'b0, 4'd0, 16'd0, 1'b0, 4'd0, 16'd0)));
    add_row(event_row(mk_event(8'd30, 32'hFFFF_FFF0, 1'b0, 4'd0, 16'd0,
                               1'b0, 4'd0, 16'd0)));
    // zero window: nothing is ever a duplicate
    add_row(reg_row(CFG_TOL_IDX, 16'd0));
    add_row(typed_row(mk_event(8'd0, 32'd50, 1'b0, 4'd0, 16'd0, 1'b0, 4'd0, 16'd0),
                      ST_STORED, 1'b0));
    add_row(typed_row(mk_event(8'd0, 32'd50, 1'b0, 4'd0, 16'd0, 1'b0, 4'd0, 16'd0),
                      ST_STORED, 1'b0));
    // widest window, right at its edge and just inside it
    add_row(reg_row(CFG_TOL_IDX, 16'hFFFF));
    add_row(event_row(mk_event(8'hFF, 32'hFFFF_0000, 1'b1, 4'd15, 16'hFFFF,
                               1'b1, 4'd0, 16'h0000)));
    add_row(event_row(mk_event(8'hFF, 32'hFFFF_0001, 1'b1, 4'd15, 16'hFFFF,
                               1'b1, 4'd0, 16'h0000)));

    for (int i = 0; i < dir_count; i++) begin
      if (dir_rows[i].kind == ROW_REG)
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
      else
        push_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random part: several register settings, extremes included. Upper bits
    // of an end-type write are junk and must be ignored.
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_TOL_IDX, 16'd0);
          write_reg(CFG_END_IDX, {8'($urandom), 8'h00});
        end
        1: begin
          write_reg(CFG_TOL_IDX, 16'hFFFF);
          write_reg(CFG_END_IDX, 16'($urandom));
        end
        2: begin
          write_reg(CFG_TOL_IDX, 16'($urandom_range(1, 200)));
          write_reg(CFG_END_IDX, 16'($urandom));
          write_reg(CFG_SPARE_IDX, 16'($urandom));
        end
        3: begin
          write_reg(CFG_TOL_IDX, TOL_RESET);
          write_reg(CFG_END_IDX, 16'($urandom));
        end
        default: begin
          write_reg(CFG_TOL_IDX, 16'($urandom));
          write_reg(CFG_END_IDX, 16'($urandom));
        end
      endcase
      repeat (PHASE_ITEMS) push_event(draw_event(), 1'b0, '0);
    end

    // Closing sequence: store a type-255 item while another type ends the
    // stream, make 255 the end type, send a duplicate of it (must not end),
    // then a fresh one (ends), then items that are all ignored.
    write_reg(CFG_TOL_IDX, 16'd1000);
    write_reg(CFG_END_IDX, 16'd200);
    anchor = mk_event(8'hFF, time_base, 1'b1, 4'd1, 16'h5A5A, 1'b1, 4'd2, 16'hA5A5);
    push_event(anchor, 1'b0, '0);
    write_reg(CFG_END_IDX, 16'h00FF);
    anchor.timestamp_ms = anchor.timestamp_ms + 32'd1;
    push_event(anchor, 1'b0, '0);
    anchor.timestamp_ms = anchor.timestamp_ms + 32'h4000_0000;
    push_event(anchor, 1'b0, '0);
    repeat (20) push_event(draw_event(), 1'b0, '0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (outcome_wr != outcome_rd) @(posedge clk);
    // watch for stray results a little longer than one full scan
    repeat (40) @(posedge clk);
    if (fault_count == 0 && outcome_wr == outcome_rd)
      $display("event_dedup_window_filter verification clean");
    else
      $display("event_dedup_window_filter verification failed");
    $finish;
  end

endmodule

### event_dedup_window_filter.f
hdl/edwf_pkg.sv
hdl/edwf_history.sv
hdl/event_dedup_window_filter.sv
dv/event_dedup_window_filter_tb.sv
